### rtl/core/zbu_pkg.sv
// zbu_pkg: shared types and constants of the zero byte unpacker
`default_nettype none

package zbu_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GROUP_BYTES = 8;
    localparam int unsigned GROUP_W     = BYTE_W * GROUP_BYTES;
    localparam int unsigned LANE_W      = $clog2(GROUP_BYTES);

    localparam logic [BYTE_W-1:0] HDR_EMPTY = 8'h00;
    localparam logic [BYTE_W-1:0] HDR_FULL  = 8'hFF;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [GROUP_W-1:0] t_group;
    typedef logic [LANE_W-1:0]  t_lane;

    typedef struct packed {
        t_group group_bytes;
        logic   group_valid;
        logic   stream_end;
        logic   malformed;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/zbu_if.sv
// zbu_if: input byte channel and output group channel
`default_nettype none

interface zbu_in_if;
    logic         valid;
    logic         ready;
    logic [7:0]   byte_in;
    logic         is_last;

    modport source (output valid, output byte_in, output is_last, input ready);
    modport sink   (input valid, input byte_in, input is_last, output ready);
endinterface

interface zbu_out_if;
    logic         valid;
    logic         ready;
    logic [63:0]  group_bytes;
    logic         group_valid;
    logic         stream_end;
    logic         malformed;

    modport source (
        output valid, output group_bytes, output group_valid,
        output stream_end, output malformed, input ready
    );
    modport sink (
        input valid, input group_bytes, input group_valid,
        input stream_end, input malformed, output ready
    );
endinterface

`default_nettype wire

### rtl/core/zbu_skid.sv
// zbu_skid: output register with one skid entry for result requests
`default_nettype none

module zbu_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output      logic             o_ready,
    input  wire zbu_pkg::t_result i_data,
    output      logic             o_valid,
    input  wire logic             i_ready,
    output      zbu_pkg::t_result o_data
);
    import zbu_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/zero_byte_unpacker.sv
// zero_byte_unpacker: rebuilds 8-byte groups from a zero-suppressed byte stream
//
// usage
//   i_in  : one packed byte per request (byte_in), is_last marks the final byte
//   o_out : one rebuilt group per request (group_bytes, byte 0 in bits 7..0),
//           with group_valid, stream_end and malformed flags
//   a header byte gives the nonzero lanes of a group, the data bytes follow in
//   lane order; after a full 0xff group a counter byte opens a run of raw groups
//   a byte that completes a group, and every final byte, makes one result
//   request; other bytes make none
// throughput and output path
//   one byte accepted per cycle, sustained while i_in.ready is high; all decoding for a byte is one
//   single pass of lane-select logic into the mode and group registers
//   a result reaches o_out through the skid stage's registered output
// reset
//   synchronous active-low; decoder returns to header mode, output is empty
// receiver stall
//   the output register holds its result; one more result lands in a skid
//   entry, after which i_in.ready drops until the receiver takes one
//   after a final byte the decoder restarts in header mode for the next stream
`default_nettype none

module zero_byte_unpacker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    zbu_in_if.sink    i_in,
    zbu_out_if.source o_out
);
    import zbu_pkg::*;

    // one-hot decoder mode
    typedef enum logic [3:0] {
        MODE_HEADER = 4'b0001,
        MODE_DATA   = 4'b0010,
        MODE_COUNT  = 4'b0100,
        MODE_RUN    = 4'b1000
    } t_mode;

    // lowest set lane of a header mask
    function automatic t_lane lowest_lane(input t_byte bits);
        t_lane idx;
        idx = '0;
        for (int k = GROUP_BYTES - 1; k >= 0; k--) begin
            if (bits[k]) begin
                idx = t_lane'(k);
            end
        end
        return idx;
    endfunction

    // drop one byte into a lane of a group
    function automatic t_group put_lane(input t_group grp, input t_lane lane, input t_byte b);
        t_group res;
        res = grp;
        for (int k = 0; k < GROUP_BYTES; k++) begin
            if (t_lane'(k) == lane) begin
                res[k*BYTE_W +: BYTE_W] = grp[k*BYTE_W +: BYTE_W] | b;
            end
        end
        return res;
    endfunction

    // decoder state
    t_mode  r_mode, n_mode;
    t_byte  r_pend, n_pend;      // header lanes still owed a byte
    t_group r_buf,  n_buf;       // group being assembled
    logic   r_full, n_full;      // current header was all-set
    t_byte  r_left, n_left;      // raw groups still owed, current one included
    t_lane  r_fill, n_fill;      // bytes already in the current raw group

    logic    in_fire;
    logic    emit;
    logic    counter_now;
    logic    bad;
    t_group  grp;
    t_group  lane_buf;
    t_result res;
    logic    res_push;
    logic    skid_ready;

    assign in_fire = i_in.valid && i_in.ready;

    always_comb begin
        n_mode      = r_mode;
        n_pend      = r_pend;
        n_buf       = r_buf;
        n_full      = r_full;
        n_left      = r_left;
        n_fill      = r_fill;
        emit        = 1'b0;
        counter_now = 1'b0;
        bad         = 1'b0;
        grp         = '0;
        lane_buf    = '0;

        case (r_mode)
            MODE_HEADER: begin
                n_buf  = '0;
                n_pend = i_in.byte_in;
                n_full = (i_in.byte_in == HDR_FULL);
                if (i_in.byte_in == HDR_EMPTY) begin
                    emit = 1'b1;     // all-zero group straight away
                end else begin
                    n_mode = MODE_DATA;
                end
            end
            MODE_DATA: begin
                lane_buf = put_lane(r_buf, lowest_lane(r_pend), i_in.byte_in);
                n_buf    = lane_buf;
                n_pend   = r_pend & (r_pend - t_byte'(1));
                if (n_pend == '0) begin
                    emit   = 1'b1;
                    grp    = lane_buf;
                    n_mode = r_full ? MODE_COUNT : MODE_HEADER;
                end
            end
            MODE_COUNT: begin
                counter_now = 1'b1;
                n_left      = i_in.byte_in;
                n_fill      = '0;
                n_buf       = '0;
                n_mode      = (i_in.byte_in != '0) ? MODE_RUN : MODE_HEADER;
            end
            MODE_RUN: begin
                lane_buf = put_lane(r_buf, r_fill, i_in.byte_in);
                if (r_fill == t_lane'(GROUP_BYTES - 1)) begin
                    emit   = 1'b1;
                    grp    = lane_buf;
                    n_buf  = '0;
                    n_fill = '0;
                    n_left = r_left - t_byte'(1);
                    if (n_left == '0) begin
                        n_mode = MODE_HEADER;
                    end
                end else begin
                    n_buf  = lane_buf;
                    n_fill = r_fill + t_lane'(1);
                end
            end
            default: begin
                n_mode = MODE_HEADER;
            end
        endcase

        // end of stream: flush a partial group or flag a cut-short run, then clear the decoder
        if (i_in.is_last) begin
            if (!counter_now) begin
                if (n_mode == MODE_DATA) begin
                    emit = 1'b1;
                    grp  = n_buf;
                end else if (n_mode == MODE_RUN) begin
                    if (n_left > t_byte'(1)) begin
                        bad  = 1'b1;
                        emit = 1'b0;
                    end else if (n_fill != '0) begin
                        emit = 1'b1;
                        grp  = n_buf;
                    end
                end
            end
            n_mode = MODE_HEADER;
            n_pend = '0;
            n_buf  = '0;
            n_full = 1'b0;
            n_left = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;
            r_pend <= '0;
            r_buf  <= '0;
            r_full <= 1'b0;
            r_left <= '0;
            r_fill <= '0;
        end else if (in_fire) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_buf  <= n_buf;
            r_full <= n_full;
            r_left <= n_left;
            r_fill <= n_fill;
        end
    end

    // result request for the skid stage
    assign res.group_bytes = emit ? grp : '0;
    assign res.group_valid = emit;
    assign res.stream_end  = i_in.is_last;
    assign res.malformed   = bad;
    assign res_push        = in_fire && (emit || i_in.is_last);

    t_result out_data;

    zbu_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_push),
        .o_ready (skid_ready),
        .i_data  (res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (out_data)
    );

    assign i_in.ready        = skid_ready;
    assign o_out.group_bytes = out_data.group_bytes;
    assign o_out.group_valid = out_data.group_valid;
    assign o_out.stream_end  = out_data.stream_end;
    assign o_out.malformed   = out_data.malformed;

    // a final byte always leaves the decoder in its reset state
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.is_last) |=>
            (r_mode == MODE_HEADER && r_left == '0 && r_fill == '0 && r_pend == '0))
        else $error("decoder not back in header mode after final byte");

    // a raw run in progress always owes at least one group
    a_run_owes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_RUN) |-> (r_left != '0))
        else $error("raw run mode with no groups left");

    // malformed is only reported on a final result that carries no group
    a_malformed_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.malformed) |-> (o_out.stream_end && !o_out.group_valid))
        else $error("malformed flag on a non-final or group-carrying result");

    // header data mode always has lanes still owed
    a_data_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DATA) |-> (r_pend != '0))
        else $error("header data mode with no pending lanes");

endmodule

`default_nettype wire

### sim/zero_byte_unpacker_tb.sv
// zero_byte_unpacker_tb: self-checking testbench of the zero byte unpacker
`timescale 1ns / 1ps

module zero_byte_unpacker_tb;
    import zbu_pkg::*;

    // run length guard, far above the slowest correct run
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // cycles to wait once nothing is owed
    localparam int unsigned SETTLE_CYCLES = 16;
    // random bytes per idle phase, four phases
    localparam int unsigned PHASE_ITEMS  = 375;

    // decoder modes, same meaning as the block's own mode register
    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_DATA,
        DEC_COUNT,
        DEC_RUN
    } dec_mode_e;

    // predicts the groups of the unpacker and checks them in order
    class unpack_scoreboard;
        t_result     expected_groups[$];
        int unsigned mismatch_count;
        dec_mode_e   mode;
        t_byte       pending;
        t_group      buffer;
        logic        hdr_full;
        t_byte       run_left;
        logic [2:0]  run_fill;

        function new();
            mismatch_count = 0;
            clear_decoder();
        endfunction

        function void clear_decoder();
            mode     = DEC_HEADER;
            pending  = '0;
            buffer   = '0;
            hdr_full = 1'b0;
            run_left = '0;
            run_fill = '0;
        endfunction

        function int pending_results();
            return expected_groups.size();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatch_count++;
        endtask

        // one accepted byte, queues the result it causes if any
        task note_byte(t_byte b, logic last);
            t_result r;
            logic    emit;
            logic    bad;
            logic    counter_now;
            t_group  grp;
            int      lane;
            emit        = 1'b0;
            bad         = 1'b0;
            counter_now = 1'b0;
            grp         = '0;
            lane        = 0;
            case (mode)
                DEC_HEADER: begin
                    buffer   = '0;
                    pending  = b;
                    hdr_full = (b == HDR_FULL);
                    if (b == HDR_EMPTY) begin
                        emit = 1'b1;
                    end else begin
                        mode = DEC_DATA;
                    end
                end
                DEC_DATA: begin
                    for (int i = 7; i >= 0; i--) begin
                        if (pending[i]) lane = i;
                    end
                    buffer[lane*8 +: 8] = buffer[lane*8 +: 8] | b;
                    pending = pending & (pending - 8'd1);
                    if (pending == '0) begin
                        emit = 1'b1;
                        grp  = buffer;
                        mode = hdr_full ? DEC_COUNT : DEC_HEADER;
                    end
                end
                DEC_COUNT: begin
                    counter_now = 1'b1;
                    run_left    = b;
                    run_fill    = '0;
                    buffer      = '0;
                    mode        = (b != '0) ? DEC_RUN : DEC_HEADER;
                end
                default: begin
                    buffer[run_fill*8 +: 8] = buffer[run_fill*8 +: 8] | b;
                    if (run_fill == 3'd7) begin
                        emit     = 1'b1;
                        grp      = buffer;
                        buffer   = '0;
                        run_fill = '0;
                        run_left = run_left - 8'd1;
                        if (run_left == '0) mode = DEC_HEADER;
                    end else begin
                        run_fill = run_fill + 3'd1;
                    end
                end
            endcase

            if (!last) begin
                if (emit) begin
                    r.group_bytes = grp;
                    r.group_valid = 1'b1;
                    r.stream_end  = 1'b0;
                    r.malformed   = 1'b0;
                    expected_groups = {expected_groups, r};
                end
            end else begin
                // final byte: flush a partial group or flag a run cut too short
                if (!counter_now) begin
                    if (mode == DEC_DATA) begin
                        emit = 1'b1;
                        grp  = buffer;
                    end else if (mode == DEC_RUN) begin
                        if (run_left >= 8'd2) begin
                            bad  = 1'b1;
                            emit = 1'b0;
                        end else if (run_fill != '0) begin
                            emit = 1'b1;
                            grp  = buffer;
                        end
                    end
                end
                r.group_bytes = emit ? grp : '0;
                r.group_valid = emit;
                r.stream_end  = 1'b1;
                r.malformed   = bad;
                expected_groups = {expected_groups, r};
                clear_decoder();
            end
        endtask

        task check_result(t_result got);
            t_result exp;
            if (expected_groups.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed, bytes %h", got.group_bytes));
            end else begin
                exp = expected_groups.pop_front();
                if (got.group_bytes !== exp.group_bytes)
                    report_mismatch($sformatf("group_bytes %h, want %h",
                                              got.group_bytes, exp.group_bytes));
                if (got.group_valid !== exp.group_valid)
                    report_mismatch($sformatf("group_valid %b, want %b",
                                              got.group_valid, exp.group_valid));
                if (got.stream_end !== exp.stream_end)
                    report_mismatch($sformatf("stream_end %b, want %b",
                                              got.stream_end, exp.stream_end));
                if (got.malformed !== exp.malformed)
                    report_mismatch($sformatf("malformed %b, want %b",
                                              got.malformed, exp.malformed));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    zbu_in_if  in_bus ();
    zbu_out_if out_bus ();

    zero_byte_unpacker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    unpack_scoreboard sb;

    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // packed stream under construction and the byte indexes worth ending on
    t_byte stream_q[$];
    int    mark_q[$];
    int    cut_floor;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // watchdog, a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("zero_byte_unpacker_tb: done, errors");
        $finish;
    end

    // receiver: check every accepted result request, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            sb.check_result('{group_bytes: out_bus.group_bytes,
                              group_valid: out_bus.group_valid,
                              stream_end:  out_bus.stream_end,
                              malformed:   out_bus.malformed});
        end
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one byte request; random gaps ahead of it, then hold until taken
    task automatic send_byte(t_byte b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.byte_in <= b;
        in_bus.is_last <= last;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_byte(b, last);
        items_sent++;
    endtask

    // the first len bytes of stream_q, the last of them flagged final
    task automatic send_stream(int len);
        for (int i = 0; i < len; i++) send_byte(stream_q[i], i == len - 1);
    endtask

    // sender holds off until every owed result has come out
    task automatic drain_results();
        in_bus.valid <= 1'b0;
        while (sb.pending_results() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // data bytes lean toward the extremes
    function automatic t_byte rand_data();
        int k;
        k = $urandom_range(99);
        if (k < 25) return 8'h00;
        if (k < 40) return 8'hFF;
        return t_byte'($urandom_range(255));
    endfunction

    // appends one header group, plus counter and raw run after a full header;
    // returns 1 when the run is longer than what was appended, so the stream
    // has to be cut inside it
    function automatic bit add_group();
        t_byte hdr;
        int    kind;
        int    count;
        int    raw_groups;
        kind = $urandom_range(9);
        case (kind)
            0:       hdr = HDR_EMPTY;
            1, 2:    hdr = HDR_FULL;
            3:       hdr = t_byte'(1) << $urandom_range(7);
            default: hdr = t_byte'($urandom_range(255));
        endcase
        stream_q = {stream_q, hdr};
        for (int i = 0; i < 8; i++) begin
            if (hdr[i]) stream_q = {stream_q, rand_data()};
        end
        mark_q = {mark_q, stream_q.size() - 1};
        if (hdr != HDR_FULL) return 1'b0;

        kind = $urandom_range(99);
        if (kind < 70) count = $urandom_range(3);
        else if (kind < 90) count = $urandom_range(12, 4);
        else count = $urandom_range(255, 13);
        stream_q = {stream_q, t_byte'(count)};
        cut_floor = stream_q.size() - 1;
        mark_q = {mark_q, cut_floor};
        // long runs only get their first few groups, the cut lands inside
        raw_groups = (count > 12) ? 3 : count;
        for (int g = 0; g < raw_groups; g++) begin
            repeat (8) stream_q = {stream_q, rand_data()};
            mark_q = {mark_q, stream_q.size() - 1};
        end
        return count > 12;
    endfunction

    // mostly well-formed streams, often cut short, some raw noise
    task automatic random_stream();
        int len;
        int k;
        bit cut_needed;
        stream_q.delete();
        mark_q.delete();
        cut_needed = 1'b0;
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(12, 1);
            repeat (len) stream_q = {stream_q, t_byte'($urandom_range(255))};
        end else begin
            k = $urandom_range(5, 1);
            repeat (k) begin
                if (!cut_needed) cut_needed = add_group();
            end
            k = $urandom_range(99);
            if (cut_needed) len = $urandom_range(stream_q.size(), cut_floor + 1);
            else if (k < 45) len = stream_q.size();
            else if (k < 70) len = $urandom_range(stream_q.size(), 1);
            else len = mark_q[$urandom_range(mark_q.size() - 1)] + 1;
        end
        send_stream(len);
    endtask

    initial begin
        sb = new();
        i_rst_n        <= 1'b0;
        in_bus.valid   <= 1'b0;
        in_bus.byte_in <= '0;
        in_bus.is_last <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty header, then a stream that ends inside a header's data
        stream_q = '{8'h00, 8'h81, 8'h11};
        send_stream(3);
        // full header with extreme data bytes, stream ends on its last byte
        stream_q = '{8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        send_stream(9);
        // zero counter, header decoding resumes with an empty header
        stream_q = '{8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                     8'h00, 8'h00};
        send_stream(11);
        drain_results();

        // idle phases: none, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            while (items_sent < 23 + PHASE_ITEMS * (phase + 1)) begin
                random_stream();
                // now and then the sender waits for the block to empty out
                if ($urandom_range(7) == 0) drain_results();
            end
            drain_results();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();
        if (sb.mismatch_count == 0 && sb.pending_results() == 0) begin
            $display("zero_byte_unpacker_tb: done, clean");
        end else begin
            $display("zero_byte_unpacker_tb: done, errors");
        end
        $finish;
    end

endmodule
